// ----- design/cba_pkg.sv -----
`default_nettype none
package cba_pkg;

   localparam int DEF_MAX_SLOTS     = 16;
   localparam int DEF_SEGMENT_BYTES = 16;
   localparam int QUEUE_DEPTH       = 2;
   localparam int MAX_MOVES         = 15;

   localparam logic [15:0] EMPTY_START = 16'hFFFF;

   localparam logic [1:0] REG_STORAGE_BASE = 2'd0;
   localparam logic [1:0] REG_STORAGE_SIZE = 2'd1;
   localparam logic [1:0] REG_TEXT_TYPE    = 2'd2;
   localparam logic [1:0] REG_INT_TYPE     = 2'd3;

   localparam logic [1:0] KIND_WRITE  = 2'd0;
   localparam logic [1:0] KIND_DELETE = 2'd1;
   localparam logic [1:0] KIND_QUERY  = 2'd2;
   localparam logic [1:0] KIND_FORMAT = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_SLOT  = 3'd1;
   localparam logic [2:0] ST_BAD_TYPE  = 3'd2;
   localparam logic [2:0] ST_NO_SPACE  = 3'd3;
   localparam logic [2:0] ST_EMPTY     = 3'd4;

   localparam logic RK_FINAL = 1'b0;
   localparam logic RK_MOVE  = 1'b1;

   typedef enum logic [2:0] {
      OP_WRITE,
      OP_DELETE,
      OP_QUERY,
      OP_FORMAT,
      OP_BAD_SLOT,
      OP_BAD_TYPE
   } op_code_type;

   // classified item as it travels from the front to the back
   typedef struct packed {
      op_code_type code;
      logic [7:0]  slot;
      logic [15:0] segs;
   } op_type;

endpackage
`default_nettype wire

// ----- design/compacting_block_allocator_core.sv -----
`default_nettype none
// Compacting block allocator: a slot table of (start, size) for up to MAX_SLOTS
// blocks kept packed from storage_base. A request item (write, delete, query,
// format) yields zero or more move orders (result_kind 1) and then one final
// answer with last set. The front stage takes an item each cycle while the
// two-entry queue has room; the back sequencer walks the slot table one entry
// a cycle. Delete, and write over an occupied slot, also run a selection sort
// over the survivors: for n surviving blocks, n rounds that each scan the table
// for the lowest unplaced start and then place that block, and a closing scan;
// each move order waits for rsp_ready. The back is a single-index sequencer.
// No clearing pass after reset. Configure only while no item is in flight.
module compacting_block_allocator_core import cba_pkg::*; #(
   parameter int MAX_SLOTS     = DEF_MAX_SLOTS,
   parameter int SEGMENT_BYTES = DEF_SEGMENT_BYTES
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_kind,
   input  wire logic [7:0]  req_block_index,
   input  wire logic [7:0]  req_data_type,
   input  wire logic [15:0] req_payload_len,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_result_kind,
   output logic [2:0]       rsp_status,
   output logic [7:0]       rsp_slot_out,
   output logic [15:0]      rsp_from_addr,
   output logic [15:0]      rsp_to_addr,
   output logic [15:0]      rsp_size_bytes,
   output logic             rsp_occupied,
   output logic [15:0]      rsp_free_bytes,
   output logic [6:0]       rsp_block_count,
   output logic             rsp_last,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   logic [15:0] base_ff, size_ff;
   logic [7:0]  text_ff, int_ff;
   logic        push, q_full, q_empty, pop;
   op_type      push_op, head_op;

   // configuration registers, write only
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= 16'd0;
         size_ff <= 16'd8192;
         text_ff <= 8'd0;
         int_ff  <= 8'd1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_STORAGE_BASE: base_ff <= csr_wdata;
            REG_STORAGE_SIZE: size_ff <= csr_wdata;
            REG_TEXT_TYPE:    text_ff <= csr_wdata[7:0];
            REG_INT_TYPE:     int_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // classify and size each item, then hand it through the queue
   cba_front #(.MAX_SLOTS(MAX_SLOTS), .SEGMENT_BYTES(SEGMENT_BYTES)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_kind, .req_block_index,
      .req_data_type, .req_payload_len,
      .text_type_code (text_ff),
      .int_type_code  (int_ff),
      .push, .push_op, .q_full
   );

   cba_fifo #(.WIDTH($bits(op_type))) u_queue (
      .clock, .reset,
      .push, .push_data (push_op), .full (q_full),
      .pop,  .pop_data  (head_op), .empty (q_empty)
   );

   // execute against the slot table and drive the result register
   cba_back #(.MAX_SLOTS(MAX_SLOTS), .SEGMENT_BYTES(SEGMENT_BYTES)) u_back (
      .clock, .reset,
      .storage_base (base_ff),
      .storage_size (size_ff),
      .op_valid (!q_empty),
      .op_head  (head_op),
      .op_pop   (pop),
      .rsp_valid, .rsp_ready, .rsp_result_kind, .rsp_status, .rsp_slot_out,
      .rsp_from_addr, .rsp_to_addr, .rsp_size_bytes, .rsp_occupied,
      .rsp_free_bytes, .rsp_block_count, .rsp_last
   );
endmodule
`default_nettype wire

// ----- design/cba_fifo.sv -----
`default_nettype none
module cba_fifo import cba_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);
   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CNTW-1:0]  cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == CNTW'(QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (do_push) mem_ff[wptr_ff] <= push_data;
   end
endmodule
`default_nettype wire

// ----- design/cba_front.sv -----
`default_nettype none
module cba_front import cba_pkg::*; #(
   parameter int MAX_SLOTS     = DEF_MAX_SLOTS,
   parameter int SEGMENT_BYTES = DEF_SEGMENT_BYTES
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_kind,
   input  wire logic [7:0]  req_block_index,
   input  wire logic [7:0]  req_data_type,
   input  wire logic [15:0] req_payload_len,
   input  wire logic [7:0]  text_type_code,
   input  wire logic [7:0]  int_type_code,
   output logic             push,
   output op_type           push_op,
   input  wire logic        q_full
);
   // ceil(len / SEGMENT_BYTES) by reciprocal multiply, exact for 17-bit numerators
   localparam int RK = 26;
   localparam logic [RK:0] RECIP = (RK+1)'(((64'd1 << RK) + SEGMENT_BYTES - 1) / SEGMENT_BYTES);

   logic        stg_v_ff, stg_v_in;
   logic [1:0]  stg_kind_ff;
   logic [7:0]  stg_idx_ff;
   logic [7:0]  stg_type_ff;
   logic [15:0] stg_len_ff;
   logic        accept;
   logic [16:0] numer;
   logic [RK+17:0] prod;

   assign push      = stg_v_ff && !q_full;
   assign req_ready = !stg_v_ff || push;
   assign accept    = req_valid && req_ready;
   assign numer     = 17'(stg_len_ff) + 17'(SEGMENT_BYTES - 1);
   assign prod      = (RK+18)'(numer) * (RK+18)'(RECIP);

   always_comb begin
      stg_v_in = stg_v_ff;
      if (accept) stg_v_in = 1'b1;
      else if (push) stg_v_in = 1'b0;
   end

   always_comb begin
      push_op.slot = stg_idx_ff;
      push_op.segs = prod[RK+15:RK];
      // format first, then slot range, then query and delete, then type for writes
      if (stg_kind_ff == KIND_FORMAT) begin
         push_op.code = OP_FORMAT;
         push_op.slot = 8'd0;
      end else if (stg_idx_ff >= 8'(MAX_SLOTS)) begin
         push_op.code = OP_BAD_SLOT;
      end else if (stg_kind_ff == KIND_QUERY) begin
         push_op.code = OP_QUERY;
      end else if (stg_kind_ff == KIND_DELETE) begin
         push_op.code = OP_DELETE;
      end else if (stg_type_ff != text_type_code && stg_type_ff != int_type_code) begin
         push_op.code = OP_BAD_TYPE;
      end else begin
         push_op.code = OP_WRITE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) stg_v_ff <= 1'b0;
      else stg_v_ff <= stg_v_in;
      if (accept) begin
         stg_kind_ff <= req_kind;
         stg_idx_ff  <= req_block_index;
         stg_type_ff <= req_data_type;
         stg_len_ff  <= req_payload_len;
      end
   end
endmodule
`default_nettype wire

// ----- design/cba_back.sv -----
`default_nettype none
module cba_back import cba_pkg::*; #(
   parameter int MAX_SLOTS     = DEF_MAX_SLOTS,
   parameter int SEGMENT_BYTES = DEF_SEGMENT_BYTES
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [15:0] storage_base,
   input  wire logic [15:0] storage_size,
   input  wire logic        op_valid,
   input  wire op_type      op_head,
   output logic             op_pop,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_result_kind,
   output logic [2:0]       rsp_status,
   output logic [7:0]       rsp_slot_out,
   output logic [15:0]      rsp_from_addr,
   output logic [15:0]      rsp_to_addr,
   output logic [15:0]      rsp_size_bytes,
   output logic             rsp_occupied,
   output logic [15:0]      rsp_free_bytes,
   output logic [6:0]       rsp_block_count,
   output logic             rsp_last
);
   localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int UW = 16 + $clog2(MAX_SLOTS + 1);
   localparam int CW = UW + 2;
   localparam int TW = 17;

   typedef enum logic [2:0] {
      S_IDLE, S_LOOKUP, S_SORT_SCAN, S_SORT_APPLY, S_SUM, S_PLACE, S_FINAL
   } state_type;

   state_type state_ff, state_in;
   logic [15:0] start_ff [MAX_SLOTS];
   logic [15:0] start_in [MAX_SLOTS];
   logic [15:0] size_ff  [MAX_SLOTS];
   logic [15:0] size_in  [MAX_SLOTS];
   logic [MAX_SLOTS-1:0] valid_ff, valid_in, done_ff, done_in;
   logic [IW-1:0] idx_ff, idx_in, best_ff, best_in;
   logic [15:0]   best_start_ff, best_start_in, dest_ff, dest_in;
   logic          found_ff, found_in;
   logic [3:0]    moves_ff, moves_in;
   op_type        op_ff, op_in;
   logic [TW-1:0] total_ff, total_in;
   logic [UW-1:0] used_ff, used_in;
   logic [6:0]    count_ff, count_in;
   logic [16:0]   at_ff, at_in;
   logic [2:0]    status_ff, status_in;
   logic          occ_ff, occ_in;
   logic [15:0]   to_ff, to_in, sz_ff, sz_in;

   logic        rv_ff, rv_in, r_kind_ff, r_kind_in, r_occ_ff, r_occ_in, r_last_ff, r_last_in;
   logic [2:0]  r_status_ff, r_status_in;
   logic [7:0]  r_slot_ff, r_slot_in;
   logic [15:0] r_from_ff, r_from_in, r_to_ff, r_to_in, r_size_ff, r_size_in;
   logic [15:0] r_free_ff, r_free_in;
   logic [6:0]  r_count_ff, r_count_in;

   logic [15:0] cur_start, cur_size;
   logic        cur_valid, cur_done, last_idx, out_free, take, found_now, moving;
   logic [IW-1:0] best_now, slot_idx;
   logic [16:0] cur_end;
   logic        go_sum, go_sort;

   assign cur_start = start_ff[idx_ff];
   assign cur_size  = size_ff[idx_ff];
   assign cur_valid = valid_ff[idx_ff];
   assign cur_done  = done_ff[idx_ff];
   assign cur_end   = {1'b0, cur_start} + {1'b0, cur_size};
   assign last_idx  = (idx_ff == IW'(MAX_SLOTS - 1));
   assign out_free  = !rv_ff || rsp_ready;
   assign slot_idx  = op_ff.slot[IW-1:0];

   always_comb begin
      state_in = state_ff;
      start_in = start_ff;
      size_in  = size_ff;
      valid_in = valid_ff;
      done_in  = done_ff;
      idx_in   = idx_ff;
      best_in  = best_ff;
      best_start_in = best_start_ff;
      dest_in  = dest_ff;
      found_in = found_ff;
      moves_in = moves_ff;
      op_in    = op_ff;
      total_in = total_ff;
      used_in  = used_ff;
      count_in = count_ff;
      at_in    = at_ff;
      status_in = status_ff;
      occ_in   = occ_ff;
      to_in    = to_ff;
      sz_in    = sz_ff;
      rv_in    = rv_ff && !rsp_ready;
      r_kind_in = r_kind_ff;
      r_status_in = r_status_ff;
      r_slot_in = r_slot_ff;
      r_from_in = r_from_ff;
      r_to_in   = r_to_ff;
      r_size_in = r_size_ff;
      r_occ_in  = r_occ_ff;
      r_free_in = r_free_ff;
      r_count_in = r_count_ff;
      r_last_in = r_last_ff;
      op_pop   = 1'b0;
      go_sum   = 1'b0;
      go_sort  = 1'b0;
      take      = cur_valid && !cur_done && (!found_ff || cur_start < best_start_ff);
      found_now = found_ff || take;
      best_now  = take ? idx_ff : best_ff;
      moving    = (cur_start != dest_ff);

      unique case (state_ff)
         S_IDLE: begin
            op_pop = op_valid;
            if (op_valid) begin
               op_in     = op_head;
               idx_in    = op_head.slot[IW-1:0];
               total_in  = TW'((TW'(op_head.segs) + TW'(2)) * TW'(SEGMENT_BYTES));
               status_in = ST_OK;
               occ_in    = 1'b0;
               to_in     = '0;
               sz_in     = '0;
               moves_in  = '0;
               unique case (op_head.code)
                  OP_FORMAT: begin
                     valid_in = '0;
                     for (int i = 0; i < MAX_SLOTS; i++) begin
                        start_in[i] = EMPTY_START;
                        size_in[i]  = '0;
                     end
                     go_sum = 1'b1;
                  end
                  OP_BAD_SLOT: begin
                     status_in = ST_BAD_SLOT;
                     go_sum    = 1'b1;
                  end
                  OP_BAD_TYPE: begin
                     status_in = ST_BAD_TYPE;
                     go_sum    = 1'b1;
                  end
                  OP_WRITE, OP_DELETE, OP_QUERY: state_in = S_LOOKUP;
                  default: go_sum = 1'b1;
               endcase
            end
         end
         S_LOOKUP: begin
            if (op_ff.code == OP_QUERY) begin
               if (cur_valid) begin
                  occ_in = 1'b1;
                  to_in  = cur_start;
                  sz_in  = cur_size;
               end
               go_sum = 1'b1;
            end else if (!cur_valid) begin
               if (op_ff.code == OP_DELETE) status_in = ST_EMPTY;
               go_sum = 1'b1;
            end else begin
               // empty the slot, then pack the survivors
               valid_in[idx_ff] = 1'b0;
               start_in[idx_ff] = EMPTY_START;
               size_in[idx_ff]  = '0;
               go_sort = 1'b1;
            end
         end
         S_SORT_SCAN: begin
            found_in = found_now;
            best_in  = best_now;
            if (take) best_start_in = cur_start;
            if (last_idx) begin
               if (!found_now) begin
                  go_sum = 1'b1;
               end else begin
                  idx_in   = best_now;
                  state_in = S_SORT_APPLY;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_SORT_APPLY: begin
            if (!(moving && moves_ff < 4'(MAX_MOVES) && !out_free)) begin
               if (moving && moves_ff < 4'(MAX_MOVES)) begin
                  rv_in       = 1'b1;
                  r_kind_in   = RK_MOVE;
                  r_status_in = ST_OK;
                  r_slot_in   = 8'(idx_ff);
                  r_from_in   = cur_start;
                  r_to_in     = dest_ff;
                  r_size_in   = cur_size;
                  r_occ_in    = 1'b0;
                  r_free_in   = '0;
                  r_count_in  = '0;
                  r_last_in   = 1'b0;
                  moves_in    = moves_ff + 1'b1;
               end
               start_in[idx_ff] = dest_ff;
               dest_in          = dest_ff + cur_size;
               done_in[idx_ff]  = 1'b1;
               idx_in           = '0;
               found_in         = 1'b0;
               state_in         = S_SORT_SCAN;
            end
         end
         S_SUM: begin
            if (cur_valid) begin
               used_in  = used_ff + UW'(cur_size);
               count_in = count_ff + 1'b1;
               if (cur_end > at_ff) at_in = cur_end;
            end
            if (last_idx) begin
               state_in = (op_ff.code == OP_WRITE) ? S_PLACE : S_FINAL;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_PLACE: begin
            if (CW'(used_ff) + CW'(total_ff) > CW'(storage_size)) begin
               status_in = ST_NO_SPACE;
            end else begin
               valid_in[slot_idx] = 1'b1;
               start_in[slot_idx] = at_ff[15:0];
               size_in[slot_idx]  = total_ff[15:0];
               used_in  = used_ff + UW'(total_ff[15:0]);
               count_in = count_ff + 1'b1;
               to_in    = at_ff[15:0];
               sz_in    = total_ff[15:0];
            end
            state_in = S_FINAL;
         end
         S_FINAL: begin
            if (out_free) begin
               rv_in       = 1'b1;
               r_kind_in   = RK_FINAL;
               r_status_in = status_ff;
               r_slot_in   = op_ff.slot;
               r_from_in   = '0;
               r_to_in     = to_ff;
               r_size_in   = sz_ff;
               r_occ_in    = occ_ff;
               r_free_in   = (used_ff < UW'(storage_size)) ?
                             16'(UW'(storage_size) - used_ff) : 16'd0;
               r_count_in  = count_ff;
               r_last_in   = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (go_sum) begin
         state_in = S_SUM;
         idx_in   = '0;
         used_in  = '0;
         count_in = '0;
         at_in    = {1'b0, storage_base};
      end
      if (go_sort) begin
         state_in = S_SORT_SCAN;
         idx_in   = '0;
         found_in = 1'b0;
         done_in  = '0;
         dest_in  = storage_base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         rv_ff    <= 1'b0;
         for (int i = 0; i < MAX_SLOTS; i++) begin
            start_ff[i] <= EMPTY_START;
            size_ff[i]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         rv_ff    <= rv_in;
         start_ff <= start_in;
         size_ff  <= size_in;
      end
      done_ff       <= done_in;
      idx_ff        <= idx_in;
      best_ff       <= best_in;
      best_start_ff <= best_start_in;
      dest_ff       <= dest_in;
      found_ff      <= found_in;
      moves_ff      <= moves_in;
      op_ff         <= op_in;
      total_ff      <= total_in;
      used_ff       <= used_in;
      count_ff      <= count_in;
      at_ff         <= at_in;
      status_ff     <= status_in;
      occ_ff        <= occ_in;
      to_ff         <= to_in;
      sz_ff         <= sz_in;
      r_kind_ff     <= r_kind_in;
      r_status_ff   <= r_status_in;
      r_slot_ff     <= r_slot_in;
      r_from_ff     <= r_from_in;
      r_to_ff       <= r_to_in;
      r_size_ff     <= r_size_in;
      r_occ_ff      <= r_occ_in;
      r_free_ff     <= r_free_in;
      r_count_ff    <= r_count_in;
      r_last_ff     <= r_last_in;
   end

   assign rsp_valid       = rv_ff;
   assign rsp_result_kind = r_kind_ff;
   assign rsp_status      = r_status_ff;
   assign rsp_slot_out    = r_slot_ff;
   assign rsp_from_addr   = r_from_ff;
   assign rsp_to_addr     = r_to_ff;
   assign rsp_size_bytes  = r_size_ff;
   assign rsp_occupied    = r_occ_ff;
   assign rsp_free_bytes  = r_free_ff;
   assign rsp_block_count = r_count_ff;
   assign rsp_last        = r_last_ff;
endmodule
`default_nettype wire

// ----- design/cba_checker.sv -----
`default_nettype none
module cba_checker import cba_pkg::*; #(
   parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_result_kind,
   input wire logic [2:0]  rsp_status,
   input wire logic        rsp_occupied,
   input wire logic [15:0] rsp_free_bytes,
   input wire logic [6:0]  rsp_block_count,
   input wire logic        rsp_last
);
   // a stalled result stays valid with its kind and last flag held
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind) && $stable(rsp_last))
      else $error("stalled result changed");

   a_last_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_result_kind == RK_FINAL)))
      else $error("last does not mark the final answer");

   a_move_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == RK_MOVE |->
         rsp_status == ST_OK && !rsp_occupied && rsp_free_bytes == 16'd0 &&
         rsp_block_count == 7'd0)
      else $error("move order carries final-answer fields");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == RK_FINAL |-> rsp_block_count <= 7'(MAX_SLOTS))
      else $error("block count exceeds slot table");
endmodule

bind compacting_block_allocator_core cba_checker #(.MAX_SLOTS(MAX_SLOTS)) u_cba_checker (.*);
`default_nettype wire
